[sv/fcsr_pkg.sv]
// Shared types and constants for the filled circle span rasterizer.
// Holds request/result words, the job word between front and back, and config.
// No dependencies.
`default_nettype none

package fcsr_pkg;

  // Field widths fixed by the interface
  localparam int COORD_BITS     = 12;
  localparam int COLOR_BITS     = 32;
  localparam int RADIUS_BITS    = 11;
  localparam int PIX_BITS       = 11;
  localparam int DIM_BITS       = 12;
  localparam int DEC_BITS       = 16;
  localparam int SUM_BITS       = COORD_BITS + 2;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 12;

  // Default depth of the job and result queues
  localparam int FIFO_DEPTH = 2;

  // Twelve draw candidates per step: four spans, eight outline pixels
  localparam int NUM_CAND  = 12;
  localparam int CAND_BITS = $clog2(NUM_CAND);

  // Largest usable frame dimension
  localparam logic [DIM_BITS-1:0] FRAME_MAX = DIM_BITS'(2048);

  // Register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LEFT_CLIP    = 2'd2;

  // Register reset values
  localparam logic [DIM_BITS-1:0] FRAME_WIDTH_RST  = 12'd1024;
  localparam logic [DIM_BITS-1:0] FRAME_HEIGHT_RST = 12'd768;
  localparam logic [PIX_BITS-1:0] LEFT_CLIP_RST    = 11'd400;

  // Request codes
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  typedef enum logic [1:0] {
    KIND_SPAN  = 2'd0,
    KIND_PIXEL = 2'd1,
    KIND_NONE  = 2'd2
  } kind_t;

  typedef struct packed {
    logic                          req_type;
    logic signed [COORD_BITS-1:0]  center_x;
    logic signed [COORD_BITS-1:0]  center_y;
    logic [RADIUS_BITS-1:0]        radius;
    logic [COLOR_BITS-1:0]         fill_color;
    logic [COLOR_BITS-1:0]         outline_color;
  } request_t;

  typedef struct packed {
    kind_t                  kind;
    logic [PIX_BITS-1:0]    row;
    logic [PIX_BITS-1:0]    col_first;
    logic [PIX_BITS-1:0]    col_last;
    logic [COLOR_BITS-1:0]  pixel_color;
    logic                   last;
    logic                   finished;
  } result_t;

  typedef struct packed {
    logic [DIM_BITS-1:0] frame_width;
    logic [DIM_BITS-1:0] frame_height;
    logic [PIX_BITS-1:0] left_clip;
  } cfg_t;

  // One classified item. mask marks the candidates that survive clipping;
  // an all-zero mask means a single acknowledge word.
  // rows: cy+y, cy-y, cy-x, cy+x. span 0 uses cx-x..cx+x, span 1 cx-y..cx+y.
  // pix_col: cx+x, cx-x, cx+y, cx-y.
  typedef struct packed {
    logic [NUM_CAND-1:0]            mask;
    logic                           done;
    logic [3:0][PIX_BITS-1:0]       rows;
    logic [1:0][PIX_BITS-1:0]       span_first;
    logic [1:0][PIX_BITS-1:0]       span_last;
    logic [3:0][PIX_BITS-1:0]       pix_col;
    logic [COLOR_BITS-1:0]          fill_color;
    logic [COLOR_BITS-1:0]          outline_color;
  } job_t;

endpackage

`default_nettype wire

[sv/fcsr_fifo.sv]
// Small synchronous FIFO with registered storage and a show-ahead head.
// Used for the job queue and the result queue. No package dependency.
`default_nettype none

module fcsr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    store [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign empty   = (count == '0);
  assign full    = (count == CNT_BITS'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = store[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_BITS'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

[sv/fcsr_front.sv]
// Front end: accepts requests, runs the midpoint circle state and
// classifies each step into a job word with its clip mask. Uses fcsr_pkg.
`default_nettype none

module fcsr_front (
  input  logic              clk,
  input  logic              rst,
  input  fcsr_pkg::request_t request,
  input  logic              push,
  input  fcsr_pkg::cfg_t    cfg,
  input  logic              queue_full,
  output fcsr_pkg::job_t    job,
  output logic              job_push
);

  import fcsr_pkg::*;

  // circle state
  logic [DIM_BITS-1:0]          step_x;
  logic [DIM_BITS-1:0]          step_y;
  logic [DEC_BITS-1:0]          decision;
  logic signed [COORD_BITS-1:0] held_center_x;
  logic signed [COORD_BITS-1:0] held_center_y;
  logic [COLOR_BITS-1:0]        held_fill_color;
  logic [COLOR_BITS-1:0]        held_outline_color;
  logic                         active;

  logic accept;
  logic is_start;
  logic idle_step;

  logic [DIM_BITS-1:0]        w_lim;
  logic [DIM_BITS-1:0]        h_lim;
  logic signed [SUM_BITS-1:0] w_m1;
  logic signed [SUM_BITS-1:0] h_s;
  logic signed [SUM_BITS-1:0] lo_s;
  logic signed [SUM_BITS-1:0] cx;
  logic signed [SUM_BITS-1:0] cy;
  logic signed [SUM_BITS-1:0] sx;
  logic signed [SUM_BITS-1:0] sy;
  logic signed [SUM_BITS-1:0] r [4];
  logic signed [SUM_BITS-1:0] c [4];
  logic [3:0]                 rv;
  logic [3:0]                 cv;
  logic signed [SUM_BITS-1:0] a_first;
  logic signed [SUM_BITS-1:0] a_last;
  logic signed [SUM_BITS-1:0] b_first;
  logic signed [SUM_BITS-1:0] b_last;
  logic                       sa;
  logic                       sb;

  logic                  dec_neg;
  logic [DEC_BITS-1:0]   diff;
  logic [DEC_BITS-1:0]   decision_next;
  logic [DIM_BITS-1:0]   step_x_next;
  logic [DIM_BITS-1:0]   step_y_next;
  logic                  done;

  assign accept    = push && !queue_full;
  assign job_push  = accept;
  assign is_start  = (request.req_type == REQ_START);
  assign idle_step = !active || (step_x > step_y);

  // frame limits, clamped to the largest frame
  assign w_lim = (cfg.frame_width > FRAME_MAX) ? FRAME_MAX : cfg.frame_width;
  assign h_lim = (cfg.frame_height > FRAME_MAX) ? FRAME_MAX : cfg.frame_height;
  assign w_m1  = signed'(SUM_BITS'(w_lim)) - SUM_BITS'(1);
  assign h_s   = signed'(SUM_BITS'(h_lim));
  assign lo_s  = signed'(SUM_BITS'(cfg.left_clip));

  // candidate rows and columns
  assign cx   = SUM_BITS'(held_center_x);
  assign cy   = SUM_BITS'(held_center_y);
  assign sx   = signed'(SUM_BITS'(step_x));
  assign sy   = signed'(SUM_BITS'(step_y));
  assign r[0] = cy + sy;
  assign r[1] = cy - sy;
  assign r[2] = cy - sx;
  assign r[3] = cy + sx;
  assign c[0] = cx + sx;
  assign c[1] = cx - sx;
  assign c[2] = cx + sy;
  assign c[3] = cx - sy;

  // per-row and per-column visibility
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rv[i] = !r[i][SUM_BITS-1] && (r[i] < h_s);
      cv[i] = (c[i] >= lo_s) && (c[i] <= w_m1);
    end
  end

  // span clipping
  assign a_first = (c[1] < lo_s) ? lo_s : c[1];
  assign a_last  = (c[0] > w_m1) ? w_m1 : c[0];
  assign b_first = (c[3] < lo_s) ? lo_s : c[3];
  assign b_last  = (c[2] > w_m1) ? w_m1 : c[2];
  assign sa      = (a_first <= a_last);
  assign sb      = (b_first <= b_last);

  // decision update, wraps at DEC_BITS
  assign dec_neg       = decision[DEC_BITS-1];
  assign diff          = DEC_BITS'(step_x) - DEC_BITS'(step_y);
  assign decision_next = dec_neg ?
      decision + DEC_BITS'({step_x, 2'b00}) + DEC_BITS'(6) :
      decision + (diff << 2) + DEC_BITS'(10);
  assign step_x_next   = step_x + DIM_BITS'(1);
  assign step_y_next   = dec_neg ? step_y : step_y - DIM_BITS'(1);
  // x+1 > y_next, kept unsigned so y reaching -1 still compares right
  assign done = dec_neg ?
      ((DIM_BITS+1)'(step_x) + (DIM_BITS+1)'(1) > (DIM_BITS+1)'(step_y)) :
      ((DIM_BITS+1)'(step_x) + (DIM_BITS+1)'(2) > (DIM_BITS+1)'(step_y));

  // job word
  always_comb begin
    job.mask          = '0;
    job.done          = 1'b0;
    job.fill_color    = held_fill_color;
    job.outline_color = held_outline_color;
    for (int i = 0; i < 4; i++) begin
      job.rows[i]    = r[i][PIX_BITS-1:0];
      job.pix_col[i] = c[i][PIX_BITS-1:0];
    end
    job.span_first[0] = a_first[PIX_BITS-1:0];
    job.span_last[0]  = a_last[PIX_BITS-1:0];
    job.span_first[1] = b_first[PIX_BITS-1:0];
    job.span_last[1]  = b_last[PIX_BITS-1:0];
    priority if (is_start) begin
      job.done = 1'b0;
    end else if (idle_step) begin
      job.done = 1'b1;
    end else begin
      job.done     = done;
      job.mask[0]  = rv[0] & sa;
      job.mask[1]  = rv[1] & sa;
      job.mask[2]  = rv[2] & sb;
      job.mask[3]  = rv[3] & sb;
      job.mask[4]  = rv[0] & cv[0];
      job.mask[5]  = rv[0] & cv[1];
      job.mask[6]  = rv[1] & cv[0];
      job.mask[7]  = rv[1] & cv[1];
      job.mask[8]  = rv[3] & cv[2];
      job.mask[9]  = rv[3] & cv[3];
      job.mask[10] = rv[2] & cv[2];
      job.mask[11] = rv[2] & cv[3];
    end
  end

  // state update on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      step_x             <= '0;
      step_y             <= '0;
      decision           <= '0;
      held_center_x      <= '0;
      held_center_y      <= '0;
      held_fill_color    <= '0;
      held_outline_color <= '0;
      active             <= 1'b0;
    end else if (accept) begin
      priority if (is_start) begin
        held_center_x      <= request.center_x;
        held_center_y      <= request.center_y;
        held_fill_color    <= request.fill_color;
        held_outline_color <= request.outline_color;
        step_x             <= '0;
        step_y             <= DIM_BITS'(request.radius);
        decision           <= DEC_BITS'(3) - DEC_BITS'({request.radius, 1'b0});
        active             <= 1'b1;
      end else if (idle_step) begin
        active <= 1'b0;
      end else begin
        step_x   <= step_x_next;
        step_y   <= step_y_next;
        decision <= decision_next;
        active   <= !done;
      end
    end
  end

endmodule

`default_nettype wire

[sv/fcsr_back.sv]
// Back end: walks the surviving candidates of one job, one result word
// per cycle while the result queue has room, and marks the final word. Uses fcsr_pkg.
`default_nettype none

module fcsr_back (
  input  logic              clk,
  input  logic              rst,
  input  fcsr_pkg::job_t    job,
  input  logic              job_valid,
  output logic              job_pop,
  output fcsr_pkg::result_t word,
  output logic              word_push,
  input  logic              out_full
);

  import fcsr_pkg::*;

  logic                 busy;
  logic [NUM_CAND-1:0]  rem;
  job_t                 cur;

  logic                 emit;
  logic                 is_ack;
  logic [NUM_CAND-1:0]  low;
  logic [NUM_CAND-1:0]  rem_next;
  logic [CAND_BITS-1:0] idx;
  logic                 finishing;

  assign emit      = busy && !out_full;
  assign is_ack    = (rem == '0);
  assign low       = rem & (~rem + NUM_CAND'(1));
  assign rem_next  = rem & ~low;
  assign finishing = emit && (is_ack || (rem_next == '0));
  assign job_pop   = job_valid && (!busy || finishing);
  assign word_push = emit;

  // index of the lowest remaining candidate
  always_comb begin
    idx = '0;
    for (int i = 0; i < NUM_CAND; i++) begin
      if (low[i]) begin
        idx = CAND_BITS'(i);
      end
    end
  end

  // result word for the selected candidate
  always_comb begin
    word.kind        = KIND_NONE;
    word.row         = '0;
    word.col_first   = '0;
    word.col_last    = '0;
    word.pixel_color = '0;
    word.last        = 1'b1;
    word.finished    = cur.done;
    if (!is_ack) begin
      word.last = (rem_next == '0);
      unique case (idx)
        4'd0, 4'd1: begin
          word.kind        = KIND_SPAN;
          word.row         = cur.rows[idx[1:0]];
          word.col_first   = cur.span_first[0];
          word.col_last    = cur.span_last[0];
          word.pixel_color = cur.fill_color;
        end
        4'd2, 4'd3: begin
          word.kind        = KIND_SPAN;
          word.row         = cur.rows[idx[1:0]];
          word.col_first   = cur.span_first[1];
          word.col_last    = cur.span_last[1];
          word.pixel_color = cur.fill_color;
        end
        // outline pixels on rows cy+y and cy-y
        4'd4, 4'd5, 4'd6, 4'd7: begin
          word.kind        = KIND_PIXEL;
          word.row         = cur.rows[{1'b0, idx[1]}];
          word.col_first   = cur.pix_col[{1'b0, idx[0]}];
          word.col_last    = cur.pix_col[{1'b0, idx[0]}];
          word.pixel_color = cur.outline_color;
        end
        // outline pixels on rows cy+x and cy-x
        4'd8, 4'd9, 4'd10, 4'd11: begin
          word.kind        = KIND_PIXEL;
          word.row         = idx[1] ? cur.rows[2] : cur.rows[3];
          word.col_first   = cur.pix_col[{1'b1, idx[0]}];
          word.col_last    = cur.pix_col[{1'b1, idx[0]}];
          word.pixel_color = cur.outline_color;
        end
        default: begin
          word.kind = KIND_NONE;
        end
      endcase
    end
  end

  // job control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rem  <= '0;
    end else if (job_pop) begin
      busy <= 1'b1;
      rem  <= job.mask;
    end else if (finishing) begin
      busy <= 1'b0;
    end else if (emit) begin
      rem <= rem_next;
    end
  end

  // job payload
  always_ff @(posedge clk) begin
    if (job_pop) begin
      cur <= job;
    end
  end

endmodule

`default_nettype wire

[sv/filled_circle_span_rasterizer.sv]
// Top level of the filled circle span rasterizer: config registers,
// front end, job queue, back end and result queue. Uses fcsr_pkg.
//
//   channel   | handshake          | payload
//   ----------+--------------------+-------------------------
//   request   | push / full        | request (request_t)
//   result    | pop / empty        | result  (result_t)
//   config    | wr_en              | wr_index, wr_data
//
// The back end gives one result word per drawn span or pixel of a step
// item (up to 12), or a single acknowledge word when none is drawn.
// The front end takes one request per cycle while the job queue (2 entries
// by default) has room; the first result of an item passes through the job
// queue, the back end's job register and the result queue.
// Synchronous reset empties both queues, ends any circle and reloads the
// register defaults. A stalled pop fills the result queue, then the job
// queue, and full rises.
`default_nettype none

module filled_circle_span_rasterizer #(
  parameter int QUEUE_DEPTH = fcsr_pkg::FIFO_DEPTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  fcsr_pkg::request_t                    request,
  output logic                                  empty,
  input  logic                                  pop,
  output fcsr_pkg::result_t                     result,
  input  logic                                  wr_en,
  input  logic [fcsr_pkg::CFG_INDEX_BITS-1:0]   wr_index,
  input  logic [fcsr_pkg::CFG_DATA_BITS-1:0]    wr_data
);

  import fcsr_pkg::*;

  cfg_t    cfg;
  job_t    job_in;
  job_t    job_out;
  logic    job_push;
  logic    job_pop;
  logic    job_full;
  logic    job_empty;
  result_t word;
  logic    word_push;
  logic    out_full;
  logic [$bits(job_t)-1:0]    job_rdata;
  logic [$bits(result_t)-1:0] res_rdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width  <= FRAME_WIDTH_RST;
      cfg.frame_height <= FRAME_HEIGHT_RST;
      cfg.left_clip    <= LEFT_CLIP_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_FRAME_WIDTH:  cfg.frame_width  <= wr_data;
        REG_FRAME_HEIGHT: cfg.frame_height <= wr_data;
        REG_LEFT_CLIP:    cfg.left_clip    <= wr_data[PIX_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign full = job_full;

  fcsr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .request    (request),
    .push       (push),
    .cfg        (cfg),
    .queue_full (job_full),
    .job        (job_in),
    .job_push   (job_push)
  );

  fcsr_fifo #(
    .WIDTH ($bits(job_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_job_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .wdata (job_in),
    .full  (job_full),
    .pop   (job_pop),
    .rdata (job_rdata),
    .empty (job_empty)
  );

  assign job_out = job_t'(job_rdata);

  fcsr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (job_out),
    .job_valid (!job_empty),
    .job_pop   (job_pop),
    .word      (word),
    .word_push (word_push),
    .out_full  (out_full)
  );

  fcsr_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (word_push),
    .wdata (word),
    .full  (out_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign result = result_t'(res_rdata);

  // acknowledge words always close their item
  ast_none_last: assert property (@(posedge clk) disable iff (rst)
      (!empty && result.kind == KIND_NONE) |-> result.last)
    else $error("acknowledge word without last");

  // a drawn span never runs backward
  ast_span_order: assert property (@(posedge clk) disable iff (rst)
      (!empty && result.kind == KIND_SPAN) |-> (result.col_first <= result.col_last))
    else $error("span with first column past last column");

  // an outline pixel covers one column
  ast_pixel_width: assert property (@(posedge clk) disable iff (rst)
      (!empty && result.kind == KIND_PIXEL) |-> (result.col_first == result.col_last))
    else $error("outline pixel wider than one column");

endmodule

`default_nettype wire
